>>> design/assert_macros.svh
// Assertion macros included by the detrender design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked property with the asynchronous reset masking it.
`define EAT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("eat assertion failed");
// Checked property that holds through reset as well.
`define EAT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("eat assertion failed");
`else
`define EAT_ASSERT(lbl, clk, rstn, prop)
`define EAT_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> design/eat_pkg.sv
`timescale 1ns / 1ps
package eat_pkg;

  // Widths of the serial arithmetic units.
  localparam int AccW  = 58;
  localparam int MulBW = 17;
  localparam int DivW  = 34;

  // Input actions.
  typedef enum logic [1:0] {
    ACT_PRICE  = 2'd0,
    ACT_RATE   = 2'd1,
    ACT_INTR   = 2'd2,
    ACT_RESUME = 2'd3
  } action_e;

  // Word sources.
  localparam logic [1:0] SRC_DEP   = 2'd0;
  localparam logic [1:0] SRC_INDEP = 2'd1;

  // Configuration register indexes.
  localparam logic REG_BASE_DECAY    = 1'b0;
  localparam logic REG_OFFLINE_RATIO = 1'b1;

  // Status of a multi-cycle unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

>>> design/event_adaptive_ema_trend.sv
`timescale 1ns / 1ps
// Event-adaptive EMA detrender. Each price word from the dependent instrument
// yields one trend word, price minus average in signed Q24.8, rounded and saturated;
// once output is ready and the feed runs, it first updates an exponential moving average
// (Q24.16). An interrupt from either instrument yields a zero word. Rate words set the
// decay to base_decay raised to a power taken from the event-count ratio. One word is
// handled at a time through a shared bit-serial multiply-accumulate unit and a bit-serial
// divider. A rate word multiplies once for each step of the power, up to
// RATIO_FACTOR squared minus one steps; an initialisation adds RATIO_FACTOR - 1 steps.
// A finished word waits in an output register, so the input is free again while it is
// still stalled downstream.
`include "assert_macros.svh"
module event_adaptive_ema_trend #(
  parameter int RATIO_FACTOR = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic [1:0]         source_i,
  input  logic [31:0]        price_i,
  input  logic [15:0]        dep_events_i,
  input  logic [15:0]        indep_events_i,
  input  logic               dep_book_ready_i,
  input  logic               indep_book_ready_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] trend_value_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_data_i
);

  localparam int AccW   = eat_pkg::AccW;
  localparam int DivW   = eat_pkg::DivW;
  localparam int MaxIdx = RATIO_FACTOR * RATIO_FACTOR;
  localparam int IdxW   = $clog2(MaxIdx + 1);
  localparam int NumK   = 2 * 256 * RATIO_FACTOR;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POWC = 3'd1;
  localparam logic [2:0] S_MACL = 3'd2;
  localparam logic [2:0] S_MACW = 3'd3;
  localparam logic [2:0] S_DIVL = 3'd4;
  localparam logic [2:0] S_DIVW = 3'd5;
  localparam logic [2:0] S_TRD  = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  localparam logic [1:0] OP_POW = 2'd0;
  localparam logic [1:0] OP_DEN = 2'd1;
  localparam logic [1:0] OP_PR1 = 2'd2;
  localparam logic [1:0] OP_PR2 = 2'd3;

  logic [2:0]              state_q;
  logic                    rates_ready_q, out_ready_q, dep_st_q, indep_st_q, feed_st_q;
  logic                    emit_q, out_valid_q;
  logic [15:0]             base_q, off_q, decay_q, p_q, indep_q;
  logic [39:0]             avg_q;
  logic [31:0]             lp_q, th_q, out_data_q;
  logic [IdxW-1:0]         cnt_q;
  logic [1:0]              mac_op_q;
  logic [AccW-1:0]         mac_a_q, mac_init_q, mac_acc;
  logic [eat_pkg::MulBW-1:0] mac_b_q;
  logic [DivW-1:0]         div_n_q, div_d_q, quot;
  eat_pkg::unit_sts_t      mac_sts, div_sts;
  logic                    mac_start, div_start, accept, out_free;
  eat_pkg::action_e        act;
  logic signed [41:0]      diff_s;
  logic signed [33:0]      t_s;
  logic [31:0]             t_sat;
  logic [IdxW-1:0]         idx;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign mac_start  = (state_q == S_MACL);
  assign div_start  = (state_q == S_DIVL);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign act        = eat_pkg::action_e'(action_i);

  // Shared serial units.
  eat_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mac_start),
    .a_i    (mac_a_q),
    .b_i    (mac_b_q),
    .init_i (mac_init_q),
    .sts_o  (mac_sts),
    .acc_o  (mac_acc)
  );

  eat_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_n_q),
    .divisor_i (div_d_q),
    .sts_o     (div_sts),
    .quot_o    (quot)
  );

  // Trend: rounded Q24.8 difference, saturated to 32 bits.
  always_comb begin
    diff_s = $signed({2'b00, lp_q, 8'h00}) - $signed({2'b00, avg_q});
    t_s    = 34'((diff_s + 42'sd128) >>> 8);
    if (t_s[33:31] == 3'b000 || t_s[33:31] == 3'b111) begin
      t_sat = t_s[31:0];
    end else if (t_s[33]) begin
      t_sat = 32'h8000_0000;
    end else begin
      t_sat = 32'h7FFF_FFFF;
    end
  end

  // Power index from the rounded ratio, clamped to its range.
  always_comb begin
    if (quot > DivW'(MaxIdx)) begin
      idx = IdxW'(MaxIdx);
    end else if (quot == '0) begin
      idx = IdxW'(1);
    end else begin
      idx = quot[IdxW-1:0];
    end
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      rates_ready_q <= 1'b0;
      out_ready_q   <= 1'b0;
      dep_st_q      <= 1'b0;
      indep_st_q    <= 1'b0;
      feed_st_q     <= 1'b0;
      emit_q        <= 1'b0;
      base_q        <= 16'd62000;
      off_q         <= 16'd256;
      avg_q         <= '0;
      lp_q          <= '0;
      decay_q       <= '0;
      th_q          <= '0;
      p_q           <= '0;
      cnt_q         <= '0;
      mac_op_q      <= OP_POW;
      mac_a_q       <= '0;
      mac_b_q       <= '0;
      mac_init_q    <= '0;
      div_n_q       <= '0;
      div_d_q       <= '0;
      indep_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          eat_pkg::REG_BASE_DECAY:    base_q <= cfg_data_i;
          eat_pkg::REG_OFFLINE_RATIO: off_q  <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            emit_q <= 1'b0;
            unique case (act)
              eat_pkg::ACT_PRICE: begin
                if (source_i == eat_pkg::SRC_DEP) begin
                  lp_q   <= price_i;
                  emit_q <= 1'b1;
                  state_q <= S_EMIT;
                  if (!out_ready_q) begin
                    if (dep_book_ready_i && rates_ready_q) begin
                      out_ready_q <= 1'b1;
                      avg_q       <= {price_i, 8'h00};
                      th_q        <= '0;
                      p_q         <= base_q;
                      cnt_q       <= IdxW'(RATIO_FACTOR - 1);
                      state_q     <= S_POWC;
                    end
                  end else if (!feed_st_q) begin
                    mac_a_q    <= AccW'(price_i);
                    mac_b_q    <= 17'h10000 - {1'b0, decay_q};
                    mac_init_q <= AccW'(128);
                    mac_op_q   <= OP_PR1;
                    state_q    <= S_MACL;
                  end
                end
              end
              eat_pkg::ACT_RATE: begin
                if (!rates_ready_q) begin
                  if (dep_book_ready_i && indep_book_ready_i) begin
                    rates_ready_q <= 1'b1;
                    avg_q         <= {lp_q, 8'h00};
                    th_q          <= '0;
                    p_q           <= base_q;
                    cnt_q         <= IdxW'(RATIO_FACTOR - 1);
                    state_q       <= S_POWC;
                  end
                end else if (!feed_st_q) begin
                  if (dep_events_i == '0) begin
                    p_q     <= base_q;
                    cnt_q   <= IdxW'(RATIO_FACTOR - 1);
                    state_q <= S_POWC;
                  end else begin
                    indep_q    <= indep_events_i;
                    mac_a_q    <= AccW'(dep_events_i);
                    mac_b_q    <= {1'b0, (off_q == '0) ? 16'd1 : off_q};
                    mac_init_q <= '0;
                    mac_op_q   <= OP_DEN;
                    state_q    <= S_MACL;
                  end
                end
              end
              eat_pkg::ACT_INTR: begin
                if (source_i == eat_pkg::SRC_DEP || source_i == eat_pkg::SRC_INDEP) begin
                  if (source_i == eat_pkg::SRC_DEP) begin
                    dep_st_q <= 1'b1;
                  end else begin
                    indep_st_q <= 1'b1;
                  end
                  feed_st_q <= 1'b1;
                  th_q      <= '0;
                  emit_q    <= 1'b1;
                  state_q   <= S_EMIT;
                end
              end
              eat_pkg::ACT_RESUME: begin
                if (source_i == eat_pkg::SRC_DEP || source_i == eat_pkg::SRC_INDEP) begin
                  if (source_i == eat_pkg::SRC_DEP) begin
                    dep_st_q <= 1'b0;
                  end else begin
                    indep_st_q <= 1'b0;
                  end
                  // The side left stalled decides whether the feed comes back.
                  if ((source_i == eat_pkg::SRC_DEP) ? !indep_st_q : !dep_st_q) begin
                    feed_st_q <= 1'b0;
                    avg_q     <= {lp_q, 8'h00};
                    th_q      <= '0;
                    p_q       <= base_q;
                    cnt_q     <= IdxW'(RATIO_FACTOR - 1);
                    state_q   <= S_POWC;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_POWC: begin
          if (cnt_q == '0) begin
            decay_q <= p_q;
            state_q <= emit_q ? S_EMIT : S_IDLE;
          end else begin
            mac_a_q    <= AccW'(p_q);
            mac_b_q    <= {1'b0, base_q};
            mac_init_q <= AccW'(32768);
            mac_op_q   <= OP_POW;
            state_q    <= S_MACL;
          end
        end
        S_MACL: state_q <= S_MACW;
        S_MACW: begin
          if (mac_sts.done) begin
            unique case (mac_op_q)
              OP_POW: begin
                p_q     <= mac_acc[31:16];
                cnt_q   <= cnt_q - 1'b1;
                state_q <= S_POWC;
              end
              OP_DEN: begin
                div_n_q <= DivW'(indep_q) * DivW'(NumK) + DivW'(mac_acc[31:0]);
                div_d_q <= DivW'({mac_acc[31:0], 1'b0});
                state_q <= S_DIVL;
              end
              OP_PR1: begin
                mac_a_q    <= AccW'(avg_q);
                mac_b_q    <= {1'b0, decay_q};
                mac_init_q <= {mac_acc[AccW-9:0], 8'h00};
                mac_op_q   <= OP_PR2;
                state_q    <= S_MACL;
              end
              OP_PR2: begin
                avg_q   <= mac_acc[55:16];
                state_q <= S_TRD;
              end
              default: ;
            endcase
          end
        end
        S_DIVL: state_q <= S_DIVW;
        S_DIVW: begin
          if (div_sts.done) begin
            p_q     <= base_q;
            cnt_q   <= idx - 1'b1;
            state_q <= S_POWC;
          end
        end
        S_TRD: begin
          th_q    <= t_sat;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Output register: holds the word until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_EMIT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT && out_free) begin
      out_data_q <= th_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign trend_value_o = $signed(out_data_q);

  // The serial multiplier is never restarted while it is running.
  `EAT_ASSERT(a_mac_free, clk_i, rst_ni, mac_start |-> !mac_sts.busy)
  // A new word appears only from the emit step.
  `EAT_ASSERT(a_emit_src, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q) == S_EMIT)
  // The feed is stalled exactly while one side is.
  `EAT_ASSERT(a_feed, clk_i, rst_ni, feed_st_q == (dep_st_q || indep_st_q))
  // Remaining power steps stay below the largest index.
  `EAT_ASSERT(a_pow_cnt, clk_i, rst_ni, (state_q == S_POWC) |-> (cnt_q < IdxW'(MaxIdx)))

endmodule

>>> design/eat_mac.sv
`timescale 1ns / 1ps
// Bit-serial multiply-accumulate: acc = init + a * b, one multiplier bit per cycle.
module eat_mac (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [eat_pkg::AccW-1:0]    a_i,
  input  logic [eat_pkg::MulBW-1:0]   b_i,
  input  logic [eat_pkg::AccW-1:0]    init_i,
  output eat_pkg::unit_sts_t          sts_o,
  output logic [eat_pkg::AccW-1:0]    acc_o
);

  localparam int CntW = $clog2(eat_pkg::MulBW + 1);

  logic [CntW-1:0]             cnt_q;
  logic                        busy_q, done_q;
  logic [eat_pkg::AccW-1:0]    a_q, acc_q;
  logic [eat_pkg::MulBW-1:0]   b_q;

  // Control: iteration count and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= CntW'(eat_pkg::MulBW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: add the shifted multiplicand when the low multiplier bit is set.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= init_i;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= {a_q[eat_pkg::AccW-2:0], 1'b0};
      b_q <= {1'b0, b_q[eat_pkg::MulBW-1:1]};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign acc_o      = acc_q;

endmodule

>>> design/eat_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module eat_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [eat_pkg::DivW-1:0]   dividend_i,
  input  logic [eat_pkg::DivW-1:0]   divisor_i,
  output eat_pkg::unit_sts_t         sts_o,
  output logic [eat_pkg::DivW-1:0]   quot_o
);

  localparam int CntW = $clog2(eat_pkg::DivW + 1);

  logic [CntW-1:0]            cnt_q;
  logic                       busy_q, done_q;
  logic [eat_pkg::DivW-1:0]   q_q, rem_q, dvs_q;
  logic [eat_pkg::DivW:0]     rem_sh, rem_sub;
  logic                       ge;

  // One trial subtraction per cycle.
  always_comb begin
    rem_sh  = {rem_q, q_q[eat_pkg::DivW-1]};
    ge      = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh - {1'b0, dvs_q};
  end

  // Control: bit count and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= CntW'(eat_pkg::DivW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend shifts out as the quotient shifts in.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[eat_pkg::DivW-1:0] : rem_sh[eat_pkg::DivW-1:0];
      q_q   <= {q_q[eat_pkg::DivW-2:0], ge};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quot_o     = q_q;

endmodule

>>> tb/sv/tb_event_adaptive_ema_trend.sv
`timescale 1ns / 1ps
module tb_event_adaptive_ema_trend;

  localparam int RatioFactor = 5;
  localparam int CycleLimit  = 3000000;
  localparam int QuietCycles = 900;
  localparam logic [1:0] SrcOther = 2'd2;
  localparam logic [1:0] SrcSpare = 2'd3;

  // Tracks the detrender state and holds the trend words still to come.
  class trend_scoreboard;
    logic [15:0] base_decay;
    logic [15:0] offline_ratio;
    bit          rates_ready, output_ready;
    bit          dep_stalled, indep_stalled, feed_stalled;
    logic [39:0] avg;
    logic [31:0] last_price;
    logic [15:0] decay_now;
    logic [31:0] trend_held;
    logic [31:0] trend_due[$];
    int          mismatches;

    function new();
      base_decay    = 16'd62000;
      offline_ratio = 16'd256;
      rates_ready   = 0;
      output_ready  = 0;
      dep_stalled   = 0;
      indep_stalled = 0;
      feed_stalled  = 0;
      avg           = '0;
      last_price    = '0;
      decay_now     = '0;
      trend_held    = '0;
      mismatches    = 0;
    endfunction

    function void write_reg(logic idx, logic [15:0] data);
      if (idx == eat_pkg::REG_BASE_DECAY) base_decay = data;
      else offline_ratio = data;
    endfunction

    // Repeated Q0.16 multiplication, each product rounded half up.
    function logic [15:0] raise_decay(int unsigned power);
      logic [63:0] p;
      p = {48'h0, base_decay};
      for (int unsigned i = 1; i < power; i++)
        p = (p * {48'h0, base_decay} + 64'd32768) >> 16;
      return p[15:0];
    endfunction

    function void restart_average();
      trend_held = '0;
      avg        = {last_price, 8'h00};
      decay_now  = raise_decay(RatioFactor);
    endfunction

    function void set_decay_from_rates(logic [15:0] dep, logic [15:0] indep);
      logic [63:0] num, den, idx, off;
      if (dep == 0) begin
        idx = 64'(RatioFactor);
      end else begin
        off = (offline_ratio == 0) ? 64'd1 : {48'h0, offline_ratio};
        num = 64'(RatioFactor) * 64'd256 * {48'h0, indep};
        den = {48'h0, dep} * off;
        idx = (64'd2 * num + den) / (64'd2 * den);
      end
      if (idx < 64'd1) idx = 64'd1;
      if (idx > 64'(RatioFactor * RatioFactor)) idx = 64'(RatioFactor * RatioFactor);
      decay_now = raise_decay(int'(idx));
    endfunction

    function void update_average();
      logic [63:0] d, sum, off, shifted;
      longint      diff, t;
      d   = {48'h0, decay_now};
      sum = (({32'h0, last_price} * (64'd65536 - d)) << 8) + {24'h0, avg} * d;
      avg = 40'((sum + 64'd32768) >> 16);
      diff = longint'({24'h0, last_price, 8'h00}) - longint'({24'h0, avg});
      // Round half up from Q24.16 to Q24.8 through a positive offset.
      off     = 64'(diff + 128 + (longint'(1) << 41));
      shifted = off >> 8;
      t       = longint'(shifted) - (longint'(1) << 33);
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      trend_held = t[31:0];
    endfunction

    // Notes one accepted input word and queues any trend word it causes.
    function void note_word(eat_pkg::action_e act, logic [1:0] src, logic [31:0] price,
                            logic [15:0] dep, logic [15:0] indep,
                            bit dep_rdy, bit indep_rdy);
      case (act)
        eat_pkg::ACT_PRICE: begin
          if (src == eat_pkg::SRC_DEP) begin
            last_price = price;
            if (!output_ready) begin
              if (dep_rdy && rates_ready) begin
                output_ready = 1;
                restart_average();
              end
            end else if (!feed_stalled) begin
              update_average();
            end
            trend_due.push_back(trend_held);
          end
        end
        eat_pkg::ACT_RATE: begin
          if (!rates_ready) begin
            if (dep_rdy && indep_rdy) begin
              rates_ready = 1;
              restart_average();
            end
          end else if (!feed_stalled) begin
            set_decay_from_rates(dep, indep);
          end
        end
        eat_pkg::ACT_INTR: begin
          if (src == eat_pkg::SRC_DEP || src == eat_pkg::SRC_INDEP) begin
            if (src == eat_pkg::SRC_DEP) dep_stalled = 1;
            else indep_stalled = 1;
            feed_stalled = 1;
            trend_held   = '0;
            trend_due.push_back('0);
          end
        end
        default: begin
          if (src == eat_pkg::SRC_DEP || src == eat_pkg::SRC_INDEP) begin
            if (src == eat_pkg::SRC_DEP) dep_stalled = 0;
            else indep_stalled = 0;
            if (!dep_stalled && !indep_stalled) begin
              restart_average();
              feed_stalled = 0;
            end
          end
        end
      endcase
    endfunction

    function void check_trend(logic [31:0] actual);
      logic [31:0] want;
      if (trend_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected trend word %0d", $signed(actual));
        return;
      end
      want = trend_due.pop_front();
      if (want !== actual) begin
        mismatches++;
        if (mismatches <= 10)
          $display("trend_value expected %0d got %0d", $signed(want), $signed(actual));
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [1:0]  action_i = '0;
  logic [1:0]  source_i = '0;
  logic [31:0] price_i = '0;
  logic [15:0] dep_events_i = '0;
  logic [15:0] indep_events_i = '0;
  logic        dep_book_ready_i = 0;
  logic        indep_book_ready_i = 0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic signed [31:0] trend_value_o;
  logic        cfg_we_i = 0;
  logic        cfg_idx_i = 0;
  logic [15:0] cfg_data_i = '0;

  trend_scoreboard sb = new();
  int  cycles = 0;
  bit  no_idle = 0;
  bit  hold_req = 0;

  event_adaptive_ema_trend #(.RATIO_FACTOR(RatioFactor)) DUT (.*);

  always #2 clk_i = ~clk_i;

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("event_adaptive_ema_trend: mismatch");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1;
        repeat (400) @(negedge clk_i);
        hold_req = 0;
      end
      out_stall_i <= !no_idle && ($urandom_range(99) < 22);
    end
  end

  // Check every accepted trend word.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_trend(trend_value_o);
  end

  // Offers one word and waits for it to be taken; called at a falling edge.
  task automatic send_word(eat_pkg::action_e act, logic [1:0] src, logic [31:0] price,
                           logic [15:0] dep, logic [15:0] indep,
                           bit dep_rdy, bit indep_rdy);
    while (!no_idle && $urandom_range(99) < 22) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    action_i           <= act;
    source_i           <= src;
    price_i            <= price;
    dep_events_i       <= dep;
    indep_events_i     <= indep;
    dep_book_ready_i   <= dep_rdy;
    indep_book_ready_i <= indep_rdy;
    in_valid_i         <= 1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(act, src, price, dep, indep, dep_rdy, indep_rdy);
    @(negedge clk_i);
  endtask

  // Waits until the block has drained, then writes both registers.
  task automatic drain_and_configure(logic [15:0] decay, logic [15:0] ratio);
    int guard;
    in_valid_i <= 0;
    guard = 0;
    while (sb.trend_due.size() != 0 && guard < CycleLimit) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (QuietCycles) @(negedge clk_i);
    cfg_we_i   <= 1;
    cfg_idx_i  <= eat_pkg::REG_BASE_DECAY;
    cfg_data_i <= decay;
    @(negedge clk_i);
    sb.write_reg(eat_pkg::REG_BASE_DECAY, decay);
    cfg_idx_i  <= eat_pkg::REG_OFFLINE_RATIO;
    cfg_data_i <= ratio;
    @(negedge clk_i);
    sb.write_reg(eat_pkg::REG_OFFLINE_RATIO, ratio);
    cfg_we_i <= 0;
    @(negedge clk_i);
  endtask

  task automatic send_random_word();
    int               pick;
    logic [31:0]      price;
    logic [15:0]      dep, indep;
    logic [1:0]       src;
    eat_pkg::action_e act;
    pick  = $urandom_range(99);
    src   = ($urandom_range(9) < 8) ? eat_pkg::SRC_DEP : 2'($urandom_range(3));
    price = ($urandom_range(9) == 0) ? {32{1'($urandom_range(1))}} : $urandom;
    dep   = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(20));
    indep = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(60));
    if (pick < 55) act = eat_pkg::ACT_PRICE;
    else if (pick < 80) act = eat_pkg::ACT_RATE;
    else if (pick < 88) begin
      act = eat_pkg::ACT_INTR;
      src = 2'($urandom_range(3));
    end else begin
      act = eat_pkg::ACT_RESUME;
      src = ($urandom_range(9) < 9) ? 2'($urandom_range(1)) : 2'($urandom_range(3));
    end
    send_word(act, src, price, dep, indep,
              $urandom_range(9) != 0, $urandom_range(9) != 0);
  endtask

  initial begin
    logic [15:0] decays[4];
    logic [15:0] ratios[4];
    int          guard;
    decays = '{16'd62000, 16'd0, 16'd65535, 16'd40000};
    ratios = '{16'd256, 16'd1, 16'd65535, 16'd0};

    repeat (9) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Directed words: readiness, extremes, stalls and ignored sources.
    drain_and_configure(16'd62000, 16'd256);
    send_word(eat_pkg::ACT_RATE, eat_pkg::SRC_DEP, 32'h0, 16'd5, 16'd5, 1, 0);
    send_word(eat_pkg::ACT_PRICE, eat_pkg::SRC_DEP, 32'h100, 16'd0, 16'd0, 1, 1);
    send_word(eat_pkg::ACT_RATE, eat_pkg::SRC_DEP, 32'h0, 16'd5, 16'd5, 1, 1);
    send_word(eat_pkg::ACT_PRICE, eat_pkg::SRC_DEP, 32'h200, 16'd0, 16'd0, 0, 1);
    send_word(eat_pkg::ACT_PRICE, eat_pkg::SRC_DEP, 32'h300, 16'd0, 16'd0, 1, 1);
    send_word(eat_pkg::ACT_PRICE, eat_pkg::SRC_DEP, 32'hFFFF_FFFF, 16'd0, 16'd0, 1, 1);
    send_word(eat_pkg::ACT_PRICE, eat_pkg::SRC_DEP, 32'h0, 16'hFFFF, 16'hFFFF, 1, 1);
    send_word(eat_pkg::ACT_RATE, eat_pkg::SRC_DEP, 32'h0, 16'd0, 16'd9, 1, 1);
    send_word(eat_pkg::ACT_RATE, eat_pkg::SRC_DEP, 32'h0, 16'd1, 16'hFFFF, 1, 1);
    send_word(eat_pkg::ACT_PRICE, eat_pkg::SRC_DEP, 32'hFFFF_FFFF, 16'd0, 16'd0, 1, 1);
    send_word(eat_pkg::ACT_RATE, eat_pkg::SRC_DEP, 32'h0, 16'hFFFF, 16'd0, 1, 1);
    send_word(eat_pkg::ACT_PRICE, eat_pkg::SRC_INDEP, 32'h1234, 16'd0, 16'd0, 1, 1);
    send_word(eat_pkg::ACT_PRICE, SrcOther, 32'h1234, 16'd0, 16'd0, 1, 1);
    send_word(eat_pkg::ACT_INTR, eat_pkg::SRC_DEP, 32'h0, 16'd0, 16'd0, 1, 1);
    send_word(eat_pkg::ACT_PRICE, eat_pkg::SRC_DEP, 32'h5000, 16'd0, 16'd0, 1, 1);
    send_word(eat_pkg::ACT_RATE, eat_pkg::SRC_DEP, 32'h0, 16'd1, 16'd50, 1, 1);
    send_word(eat_pkg::ACT_INTR, eat_pkg::SRC_INDEP, 32'h0, 16'd0, 16'd0, 1, 1);
    send_word(eat_pkg::ACT_INTR, SrcOther, 32'h0, 16'd0, 16'd0, 1, 1);
    send_word(eat_pkg::ACT_RESUME, eat_pkg::SRC_DEP, 32'h0, 16'd0, 16'd0, 1, 1);
    send_word(eat_pkg::ACT_RESUME, SrcSpare, 32'h0, 16'd0, 16'd0, 1, 1);
    send_word(eat_pkg::ACT_RESUME, eat_pkg::SRC_INDEP, 32'h0, 16'd0, 16'd0, 1, 1);
    send_word(eat_pkg::ACT_PRICE, eat_pkg::SRC_DEP, 32'h8000_0000, 16'd0, 16'd0, 1, 1);
    send_word(eat_pkg::ACT_PRICE, eat_pkg::SRC_DEP, 32'h0000_0001, 16'd0, 16'd0, 1, 1);

    // Random phases, one per register setting.
    for (int ph = 0; ph < 4; ph++) begin
      drain_and_configure(decays[ph], ratios[ph]);
      for (int n = 0; n < 160; n++) begin
        no_idle = (ph == 1 && n >= 40 && n < 100);
        if (ph == 2 && n == 30) hold_req = 1;
        send_random_word();
      end
      no_idle = 0;
    end
    in_valid_i <= 0;

    // Drain, then allow the block to settle.
    guard = 0;
    while (sb.trend_due.size() != 0 && guard < CycleLimit) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (QuietCycles) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.trend_due.size() == 0) begin
      $display("event_adaptive_ema_trend: match");
    end else begin
      $display("event_adaptive_ema_trend: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/eat_pkg.sv
design/eat_mac.sv
design/eat_div.sv
design/event_adaptive_ema_trend.sv
tb/sv/tb_event_adaptive_ema_trend.sv
